// ===== hdl/vsc_pkg.sv =====
// Package for the Vigenere symbol cipher: alphabet tables, widths and
// register codes shared by the key store, the substitution unit and the top level.
// It depends on nothing else.
package vsc_pkg;

   localparam int unsigned KEY_MAX_BYTES_DEFAULT = 32;
   localparam int unsigned ALPHA_SIZE            = 89;
   localparam int unsigned SYM_W                 = 8;
   localparam int unsigned IDX_W                 = 7;
   localparam int unsigned LEN_W                 = 6;
   localparam int unsigned CSR_INDEX_W           = 3;
   localparam int unsigned CSR_DATA_W            = 64;
   localparam int unsigned KEY_WORD_BYTES        = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE        = 3'd0,
      CSR_KEY_LENGTH  = 3'd1,
      CSR_KEY_LO      = 3'd2,
      CSR_KEY_MID_LO  = 3'd3,
      CSR_KEY_MID_HI  = 3'd4,
      CSR_KEY_HI      = 3'd5
   } csr_reg_type;

   typedef enum logic {
      MODE_ENCRYPT = 1'b0,
      MODE_DECRYPT = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic [SYM_W-1:0]       key_byte;
   } key_sel_type;

   // Alphabet index of a byte, or ALPHA_SIZE when the byte is not in the alphabet.
   function automatic logic [IDX_W-1:0] symbol_index(input logic [SYM_W-1:0] c);
      logic [IDX_W-1:0] idx;
      idx = IDX_W'(ALPHA_SIZE);
      case (c) inside
         [8'h30:8'h39]: idx = IDX_W'(c - 8'h30);
         [8'h41:8'h5A]: idx = IDX_W'(c - 8'h41 + 8'd10);
         [8'h61:8'h7A]: idx = IDX_W'(c - 8'h61 + 8'd36);
         [8'h20:8'h2F]: idx = IDX_W'(c - 8'h20 + 8'd62);
         [8'h3A:8'h3F]: idx = IDX_W'(c - 8'h3A + 8'd78);
         8'h60:         idx = 7'd84;
         8'h7B:         idx = 7'd85;
         8'h7D:         idx = 7'd86;
         8'h7C:         idx = 7'd87;
         8'h7E:         idx = 7'd88;
         default:       idx = IDX_W'(ALPHA_SIZE);
      endcase
      return idx;
   endfunction

   // Byte at an alphabet index below ALPHA_SIZE.
   function automatic logic [SYM_W-1:0] symbol_at(input logic [IDX_W-1:0] i);
      logic [SYM_W-1:0] c;
      logic [SYM_W-1:0] ie;
      ie = SYM_W'(i);
      c  = 8'h20;
      case (i) inside
         [7'd0:7'd9]:   c = 8'h30 + ie;
         [7'd10:7'd35]: c = 8'h41 + ie - 8'd10;
         [7'd36:7'd61]: c = 8'h61 + ie - 8'd36;
         [7'd62:7'd77]: c = 8'h20 + ie - 8'd62;
         [7'd78:7'd83]: c = 8'h3A + ie - 8'd78;
         7'd84:         c = 8'h60;
         7'd85:         c = 8'h7B;
         7'd86:         c = 8'h7D;
         7'd87:         c = 8'h7C;
         7'd88:         c = 8'h7E;
         default:       c = 8'h20;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/vsc_key_store.sv =====
// Key store of the Vigenere symbol cipher: configuration registers and the
// key position counter that picks one key byte for each accepted transfer.
// It depends on vsc_pkg.
module vsc_key_store
   import vsc_pkg::*;
#(
   parameter int unsigned KEY_MAX_BYTES = KEY_MAX_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   step,
   input  logic                   restart,
   output key_sel_type            key_sel
);

   localparam int unsigned POS_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

   mode_type         mode_ff;
   logic [LEN_W-1:0] key_length_ff;
   logic [SYM_W-1:0] key_ff [KEY_MAX_BYTES];
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;

   logic [LEN_W-1:0] len_eff;
   logic [POS_W-1:0] pos_sel;
   logic [LEN_W-1:0] pos_start;
   logic [LEN_W-1:0] pos_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_ENCRYPT;
         key_length_ff <= LEN_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODE:       mode_ff <= mode_type'(csr_wdata[0]);
            CSR_KEY_LENGTH: key_length_ff <= csr_wdata[LEN_W-1:0];
            default:        ;
         endcase
      end
   end

   for (genvar n = 0; n < KEY_MAX_BYTES; n++) begin : g_key_byte
      always_ff @(posedge clock) begin
         if (reset) begin
            key_ff[n] <= '0;
         end else if (csr_write &&
                      csr_index == CSR_INDEX_W'(int'(CSR_KEY_LO) + n / KEY_WORD_BYTES)) begin
            key_ff[n] <= csr_wdata[(n % KEY_WORD_BYTES) * SYM_W +: SYM_W];
         end
      end
   end

   always_comb begin
      if (key_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (key_length_ff > LEN_W'(KEY_MAX_BYTES)) begin
         len_eff = LEN_W'(KEY_MAX_BYTES);
      end else begin
         len_eff = key_length_ff;
      end

      pos_start = restart ? '0 : LEN_W'(pos_ff);
      if (pos_start >= len_eff) begin
         pos_start = '0;
      end
      pos_sel = pos_start[POS_W-1:0];

      pos_inc = pos_start + LEN_W'(1);
      if (pos_inc >= len_eff) begin
         pos_in = '0;
      end else begin
         pos_in = pos_inc[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (step) begin
         pos_ff <= pos_in;
      end
   end

   assign key_sel.mode     = mode_ff;
   assign key_sel.key_byte = key_ff[pos_sel];

endmodule

// ===== hdl/vsc_substitute.sv =====
// Substitution unit of the Vigenere symbol cipher: alphabet lookups of the
// message and key bytes and the add or subtract modulo the alphabet size.
// It depends on vsc_pkg.
module vsc_substitute
   import vsc_pkg::*;
(
   input  logic [SYM_W-1:0] symbol_in,
   input  key_sel_type      key_sel,
   output logic [SYM_W-1:0] symbol_out
);

   logic [IDX_W-1:0] m_idx;
   logic [IDX_W-1:0] k_idx;
   logic [IDX_W:0]   sum;
   logic [IDX_W:0]   reduced;

   always_comb begin
      m_idx = symbol_index(symbol_in);
      k_idx = symbol_index(key_sel.key_byte);

      if (key_sel.mode == MODE_DECRYPT) begin
         sum = {1'b0, m_idx} + (IDX_W+1)'(ALPHA_SIZE) - {1'b0, k_idx};
      end else begin
         sum = {1'b0, m_idx} + {1'b0, k_idx};
      end

      if (sum >= (IDX_W+1)'(ALPHA_SIZE)) begin
         reduced = sum - (IDX_W+1)'(ALPHA_SIZE);
      end else begin
         reduced = sum;
      end

      if (m_idx < IDX_W'(ALPHA_SIZE) && k_idx < IDX_W'(ALPHA_SIZE)) begin
         symbol_out = symbol_at(reduced[IDX_W-1:0]);
      end else begin
         symbol_out = symbol_in;
      end
   end

endmodule

// ===== hdl/vigenere_symbol_cipher.sv =====
// Vigenere symbol cipher over an 89-symbol alphabet, one byte per transfer.
// A result passes through the input register, then the result register, before it is offered
// and transferred on the response channel. Throughput: one byte per cycle, limited only by
// the result channel's stall. Reset is synchronous and active high: mode encrypt, key
// length 1, key bytes zero, key position zero, both stages empty.
module vigenere_symbol_cipher
   import vsc_pkg::*;
#(
   parameter int unsigned KEY_MAX_BYTES = KEY_MAX_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SYM_W-1:0]       req_symbol_in,
   input  logic                   req_restart,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SYM_W-1:0]       rsp_symbol_out,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic             in_valid_ff;
   logic [SYM_W-1:0] in_symbol_ff;
   key_sel_type      in_key_ff;
   logic             out_valid_ff;
   logic [SYM_W-1:0] out_symbol_ff;

   logic             out_load;
   logic             in_load;
   logic             req_take;
   key_sel_type      key_sel;
   logic [SYM_W-1:0] sub_symbol;

   assign out_load  = !out_valid_ff || !rsp_stall;
   assign in_load   = !in_valid_ff || out_load;
   assign req_stall = !in_load;
   assign req_take  = req_valid && in_load;
   assign csr_ready = 1'b1;

   vsc_key_store #(
      .KEY_MAX_BYTES (KEY_MAX_BYTES)
   ) u_key_store (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (req_take),
      .restart   (req_restart),
      .key_sel   (key_sel)
   );

   vsc_substitute u_substitute (
      .symbol_in  (in_symbol_ff),
      .key_sel    (in_key_ff),
      .symbol_out (sub_symbol)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_load) begin
            in_valid_ff <= req_valid;
         end
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_symbol_ff <= req_symbol_in;
         in_key_ff    <= key_sel;
      end
      if (out_load && in_valid_ff) begin
         out_symbol_ff <= sub_symbol;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_symbol_out = out_symbol_ff;

endmodule
